>>> rtl/aes_block_cipher_defines.svh
// Assertion macros for the AES block cipher.
// No dependencies.
`ifndef AES_BLOCK_CIPHER_DEFINES_SVH
`define AES_BLOCK_CIPHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define AES_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("aes check failed");
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("aes check failed");
`endif

>>> rtl/aes_pkg.sv
// AES package: S-box tables, field helpers and the sequencer state type.
// Used by aes_block_cipher; no dependencies.
package aes_pkg;
	typedef enum logic [2:0] {
		ST_IDLE, ST_KEXP, ST_KINV, ST_INIT, ST_ROUND, ST_DONE
	} aes_state_t;

	localparam logic [1:0] REG_KEY_SIZE = 2'd0;
	localparam logic [7:0] RCON_INIT = 8'h01;

	localparam logic [7:0] FWD_SBOX [256] = '{
	8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
	8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
	8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
	8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
	8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
	8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
	8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
	8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
	8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
	8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
	8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
	8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
	8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
	8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
	8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
	8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

	localparam logic [7:0] INV_SBOX [256] = '{
	8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
	8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
	8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
	8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
	8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
	8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
	8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
	8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
	8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
	8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
	8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
	8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
	8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
	8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
	8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
	8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};

	function automatic logic [7:0] xtime(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] t);
		return {FWD_SBOX[t[31:24]], FWD_SBOX[t[23:16]], FWD_SBOX[t[15:8]], FWD_SBOX[t[7:0]]};
	endfunction

	function automatic logic [31:0] mix_col(input logic [31:0] w);
		logic [7:0] x0, x1, x2, x3;
		x0 = w[31:24]; x1 = w[23:16]; x2 = w[15:8]; x3 = w[7:0];
		return {xtime(x0) ^ xtime(x1) ^ x1 ^ x2 ^ x3,
			x0 ^ xtime(x1) ^ xtime(x2) ^ x2 ^ x3,
			x0 ^ x1 ^ xtime(x2) ^ xtime(x3) ^ x3,
			xtime(x0) ^ x0 ^ x1 ^ x2 ^ xtime(x3)};
	endfunction

	// inverse mix: multiply by 0e,0b,0d,09 via x2,x4,x8 terms
	function automatic logic [31:0] inv_mix_col(input logic [31:0] w);
		logic [7:0] x [4];
		logic [7:0] m2 [4], m4 [4], m8 [4], m9 [4], mb [4], md [4], me [4];
		for (int i = 0; i < 4; i++) begin
			x[i] = w[31-8*i -: 8];
			m2[i] = xtime(x[i]);
			m4[i] = xtime(m2[i]);
			m8[i] = xtime(m4[i]);
			m9[i] = m8[i] ^ x[i];
			mb[i] = m8[i] ^ m2[i] ^ x[i];
			md[i] = m8[i] ^ m4[i] ^ x[i];
			me[i] = m8[i] ^ m4[i] ^ m2[i];
		end
		return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
			m9[0] ^ me[1] ^ mb[2] ^ md[3],
			md[0] ^ m9[1] ^ me[2] ^ mb[3],
			mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction
endpackage

>>> rtl/aes_block_cipher.sv
// AES-128/192/256 block cipher: key expansion, round sequencer and round unit.
// Depends on aes_pkg and aes_block_cipher_defines.svh.
// Each item takes an initial whitening step and then Nr rounds; the first item after
// reset or a config write is preceded by key expansion (forward words, then the
// inverse-mixed decryption words).
// One item at a time: start is ignored while busy, set by the single shared round unit.
// The receiver cannot stall: done pulses one cycle with the result.
// Reset (arst_n low, async) clears control state and forces expansion again.
`include "aes_block_cipher_defines.svh"
module aes_block_cipher import aes_pkg::*; #(
	parameter int ROUND_KEY_WORDS = 60
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        req_type,
	input  logic [63:0] block_in_hi,
	input  logic [63:0] block_in_lo,
	output logic        done,
	output logic [63:0] block_out_hi,
	output logic [63:0] block_out_lo,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	localparam int AW = $clog2(ROUND_KEY_WORDS);
	localparam int RK_ROWS = ROUND_KEY_WORDS / 4;
	localparam int RW = $clog2(RK_ROWS);

	aes_state_t state_q, state_d;

	logic [1:0]  key_size_q;
	logic [63:0] key_word_q [4];
	logic        expanded_q;

	// round keys: one 128-bit row per round, each round reads one whole row
	logic [127:0] enc_rk_q [RK_ROWS];
	logic [127:0] dec_rk_q [RK_ROWS];

	// last eight expanded words, newest in slot 0
	logic [31:0] win_q [8];

	logic [AW:0] widx_q;
	logic [7:0]  rcon_q;
	logic [2:0]  nk_pos_q;
	logic [3:0]  round_q;
	logic        dec_q;
	logic [127:0] st_q;

	// effective key size after saturation and store fit
	logic [1:0] ks_eff;
	logic [3:0] nk, nr;
	logic [AW:0] words;
	always_comb begin
		ks_eff = (key_size_q == 2'd3) ? 2'd2 : key_size_q;
		if (ks_eff == 2'd2 && ROUND_KEY_WORDS < 60) ks_eff = 2'd1;
		if (ks_eff == 2'd1 && ROUND_KEY_WORDS < 52) ks_eff = 2'd0;
		nk = 4'd4 + {1'b0, ks_eff, 1'b0};
		nr = nk + 4'd6;
		words = (AW+1)'({nr + 4'd1, 2'b00});
	end

	assign busy = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	wire cfg_fire = cfg_valid && cfg_ready;
	wire go = start && !busy;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (go) state_d = expanded_q ? ST_INIT : ST_KEXP;
			ST_KEXP: if (widx_q == words - 1'b1) state_d = ST_KINV;
			ST_KINV: if (widx_q == words - 1'b1) state_d = ST_INIT;
			ST_INIT: state_d = ST_ROUND;
			ST_ROUND: if (round_q == nr) state_d = ST_DONE;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// key expansion step: one word a cycle, operands from the word window
	logic [31:0] key_w [8];
	logic [31:0] prev_w, back_w, t_w, new_w, kinv_w;
	logic [RW-1:0] wrow;
	logic [1:0]  wcol;
	always_comb begin
		for (int j = 0; j < 8; j++)
			key_w[j] = j[0] ? key_word_q[j >> 1][31:0] : key_word_q[j >> 1][63:32];
		wrow = widx_q[RW+1:2];
		wcol = widx_q[1:0];
		prev_w = win_q[0];
		back_w = win_q[3'(nk - 4'd1)];
		t_w = prev_w;
		if (nk_pos_q == 3'd0) t_w = sub_word({prev_w[23:0], prev_w[31:24]}) ^ {rcon_q, 24'd0};
		else if (nk > 4'd6 && nk_pos_q == 3'd4) t_w = sub_word(prev_w);
		new_w = back_w ^ t_w;
		kinv_w = enc_rk_q[wrow][32*(3 - int'(wcol)) +: 32];
	end

	// round unit: one round a cycle on the state word
	logic [3:0]  rk_round;
	logic [127:0] rk, sub_sh, mixed, rnd_out;
	logic        last_round;
	always_comb begin
		rk_round = dec_q ? (nr - round_q) : round_q;
		rk = (dec_q && round_q != nr) ? dec_rk_q[RW'(rk_round)] : enc_rk_q[RW'(rk_round)];
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++) begin
				if (dec_q)
					sub_sh[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[st_q[127-8*(4*c+r) -: 8]];
				else
					sub_sh[127-8*(4*c+r) -: 8] = FWD_SBOX[st_q[127-8*(4*((c+r)%4)+r) -: 8]];
			end
		for (int c = 0; c < 4; c++)
			mixed[127-32*c -: 32] = dec_q ? inv_mix_col(sub_sh[127-32*c -: 32])
				: mix_col(sub_sh[127-32*c -: 32]);
		last_round = (round_q == nr);
		rnd_out = (last_round ? sub_sh : mixed) ^ rk;
	end

	// initial whitening key: round 0 for encrypt, round Nr for decrypt
	logic [127:0] rk0;
	assign rk0 = enc_rk_q[RW'(dec_q ? nr : 4'd0)];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= 2'd0;
			expanded_q <= 1'b0;
			widx_q <= '0;
			round_q <= 4'd0;
			rcon_q <= RCON_INIT;
			nk_pos_q <= 3'd0;
			dec_q <= 1'b0;
			done <= 1'b0;
			st_q <= '0;
			for (int i = 0; i < 4; i++) key_word_q[i] <= 64'd0;
		end else begin
			done <= 1'b0;
			if (cfg_fire && cfg_index <= 3'd4) begin
				// any write to index 0..4 forces a fresh expansion
				if (cfg_index == 3'(REG_KEY_SIZE)) key_size_q <= cfg_data[1:0];
				else key_word_q[2'(cfg_index - 3'd1)] <= cfg_data;
				expanded_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (go) begin
					dec_q <= req_type;
					st_q <= {block_in_hi, block_in_lo};
					if (!expanded_q) begin
						// words beyond Nk are rewritten by the expansion
						enc_rk_q[0] <= {key_word_q[0], key_word_q[1]};
						enc_rk_q[1] <= {key_word_q[2], key_word_q[3]};
						for (int j = 0; j < 8; j++)
							win_q[j] <= key_w[3'(nk - 4'd1 - 4'(j))];
						widx_q <= (AW+1)'(nk);
						nk_pos_q <= 3'd0;
						rcon_q <= RCON_INIT;
					end
				end
				ST_KEXP: begin
					enc_rk_q[wrow][32*(3 - int'(wcol)) +: 32] <= new_w;
					win_q[0] <= new_w;
					for (int j = 1; j < 8; j++) win_q[j] <= win_q[j-1];
					if (nk_pos_q == 3'd0) rcon_q <= xtime(rcon_q);
					nk_pos_q <= (nk_pos_q == 3'(nk - 4'd1)) ? 3'd0 : nk_pos_q + 3'd1;
					widx_q <= (widx_q == words - 1'b1) ? '0 : widx_q + 1'b1;
				end
				ST_KINV: begin
					dec_rk_q[wrow][32*(3 - int'(wcol)) +: 32] <= inv_mix_col(kinv_w);
					widx_q <= widx_q + 1'b1;
					if (widx_q == words - 1'b1) expanded_q <= 1'b1;
				end
				ST_INIT: begin
					st_q <= st_q ^ rk0;
					round_q <= 4'd1;
				end
				ST_ROUND: begin
					st_q <= rnd_out;
					if (last_round) begin
						round_q <= 4'd0;
						done <= 1'b1;
					end else round_q <= round_q + 4'd1;
				end
				default: ;
			endcase
		end
	end

	assign block_out_hi = st_q[127:64];
	assign block_out_lo = st_q[63:0];

	`AES_ASSERT_IMP(a_done_once, done, state_q == ST_DONE)
	`AES_ASSERT_NXT(a_round_bound, state_q == ST_ROUND, round_q <= 4'd14)
	`AES_ASSERT_IMP(a_init_expanded, state_q == ST_INIT, expanded_q)
	`AES_ASSERT_NXT(a_cfg_clears, cfg_fire && cfg_index <= 3'd4, !expanded_q)
endmodule
